FILE: hdl/fot_pkg.sv
// shared widths, types and register indexes for the field occlusion test
package fot_pkg;

  localparam int CW      = 24;          // coordinate width
  localparam int RW      = 23;          // register and radius width
  localparam int XW      = CW + 2;      // widened signed working width
  localparam int PW      = 2 * XW;      // product width
  localparam int MH      = PW / 2;      // partial product split
  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  localparam logic [1:0] REG_HALF_LENGTH = 2'd0;
  localparam logic [1:0] REG_NET_DEPTH   = 2'd1;
  localparam logic [1:0] REG_HALF_WIDTH  = 2'd2;

  typedef struct packed {
    logic [RW-1:0] half_length;
    logic [RW-1:0] net_depth;
    logic [RW-1:0] half_width;
  } fot_cfg_t;

  typedef struct packed {
    logic                 rej;
    logic                 w_pos;
    logic                 l_pos;
    logic signed [XW-1:0] cz;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] dz;
    logic signed [XW-1:0] b0;
    logic signed [XW-1:0] b1;
    logic signed [XW-1:0] b2;
    logic signed [XW-1:0] b3;
    logic [RW-1:0]        r;
  } fot_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fot_qctl_t;

endpackage

FILE: hdl/fot_front.sv
// front end: early rejects, sphere lift and plane operands
module fot_front (
  input  fot_pkg::fot_cfg_t                cfg,
  input  logic signed [fot_pkg::CW-1:0]    cam_x,
  input  logic signed [fot_pkg::CW-1:0]    cam_y,
  input  logic signed [fot_pkg::CW-1:0]    cam_z,
  input  logic signed [fot_pkg::CW-1:0]    obj_x,
  input  logic signed [fot_pkg::CW-1:0]    obj_y,
  input  logic signed [fot_pkg::CW-1:0]    obj_z,
  input  logic [fot_pkg::RW-1:0]           obj_radius,
  output fot_pkg::fot_item_t               item
);

  logic signed [fot_pkg::XW-1:0] l_s, w_s, cx, cy, cz, ox, oy, oz, r_s, ozc;
  logic cam_in, obj_in, opp;

  always_comb begin
    l_s = fot_pkg::XW'(cfg.half_length) + fot_pkg::XW'(cfg.net_depth);
    w_s = fot_pkg::XW'(cfg.half_width);
    cx  = fot_pkg::XW'(cam_x);
    cy  = fot_pkg::XW'(cam_y);
    cz  = fot_pkg::XW'(cam_z);
    ox  = fot_pkg::XW'(obj_x);
    oy  = fot_pkg::XW'(obj_y);
    oz  = fot_pkg::XW'(obj_z);
    r_s = fot_pkg::XW'(obj_radius);

    cam_in = (cx > -l_s) && (cx < l_s) && (cy > -w_s) && (cy < w_s);
    obj_in = (ox > -l_s) && (ox < l_s) && (oy > -w_s) && (oy < w_s);
    opp    = ((cx < -l_s) && (ox > l_s)) || ((cx > l_s) && (ox < -l_s)) ||
             ((cy < -w_s) && (oy > w_s)) || ((cy > w_s) && (oy < -w_s));

    // keep the sphere above the ground
    ozc = (oz < r_s) ? r_s : oz;

    item.rej   = (cam_in && !obj_in) || opp;
    item.w_pos = (w_s != '0);
    item.l_pos = (l_s != '0);
    item.cz    = cz;
    item.dx    = ox - cx;
    item.dy    = oy - cy;
    item.dz    = ozc - cz;
    item.b0    = l_s + cx;
    item.b1    = l_s - cx;
    item.b2    = w_s - cy;
    item.b3    = w_s + cy;
    item.r     = obj_radius;
  end

endmodule

FILE: hdl/fot_mid_queue.sv
// short queue between front and back
module fot_mid_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fot_pkg::fot_item_t item_in,
  input  logic               pop,
  output fot_pkg::fot_item_t item_out,
  output fot_pkg::fot_qctl_t st
);

  fot_pkg::fot_item_t mem [fot_pkg::MQ_DEPTH];
  logic [fot_pkg::MQ_AW-1:0] wr_r, rd_r;
  logic [fot_pkg::MQ_AW:0]   cnt_r;

  assign st.full  = (cnt_r == (fot_pkg::MQ_AW+1)'(fot_pkg::MQ_DEPTH));
  assign st.empty = (cnt_r == '0);
  assign item_out = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: hdl/fot_mul.sv
// two-stage wide unsigned multiplier built from four partial products
module fot_mul (
  input  logic                      clk,
  input  logic [fot_pkg::PW-1:0]    a,
  input  logic [fot_pkg::PW-1:0]    b,
  output logic [2*fot_pkg::PW-1:0]  p
);

  logic [2*fot_pkg::MH-1:0] ll_r, lh_r, hl_r, hh_r;

  always_ff @(posedge clk) begin
    ll_r <= a[fot_pkg::MH-1:0] * b[fot_pkg::MH-1:0];
    lh_r <= a[fot_pkg::MH-1:0] * b[fot_pkg::PW-1:fot_pkg::MH];
    hl_r <= a[fot_pkg::PW-1:fot_pkg::MH] * b[fot_pkg::MH-1:0];
    hh_r <= a[fot_pkg::PW-1:fot_pkg::MH] * b[fot_pkg::PW-1:fot_pkg::MH];
  end

  always_ff @(posedge clk) begin
    p <= {hh_r, ll_r}
       + ((2*fot_pkg::PW)'(lh_r) << fot_pkg::MH)
       + ((2*fot_pkg::PW)'(hl_r) << fot_pkg::MH);
  end

endmodule

FILE: hdl/fot_back.sv
// back end: plane tests over a fixed pipeline, result queue
module fot_back (
  input  logic               clk,
  input  logic               rst_n,
  input  fot_pkg::fot_item_t head,
  input  fot_pkg::fot_qctl_t mq_st,
  output logic               mq_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic               out_occluding
);

  localparam int PW = fot_pkg::PW;

  // stage 1: products
  logic v1_r, rej1_r, wp1_r, lp1_r;
  logic signed [PW-1:0] czdx_r, czdy_r, cz2_r;
  logic signed [PW-1:0] bdz_r [4];
  logic signed [PW-1:0] bb_r  [4];
  logic [PW-1:0]        r2_r;
  // stage 2: plane sums and normal lengths
  logic v2_r, rej2_r, wp2_r, lp2_r;
  logic [3:0]           act2_r;
  logic [PW-1:0]        sm_r [4];
  logic [PW-1:0]        nn_r [4];
  logic [PW-1:0]        r2b_r;
  // stages 3 and 4: wide squares and radius-normal products
  logic v3_r, v4_r, rej3_r, rej4_r, wp3_r, wp4_r, lp3_r, lp4_r;
  logic [3:0]           act3_r, act4_r;
  logic [2*PW-1:0]      sq [4];
  logic [2*PW-1:0]      rn [4];

  logic signed [PW:0]   s_nxt [4];
  logic [3:0]           beyond;
  logic                 occ;

  // output queue
  logic                     oq_mem [fot_pkg::OQ_DEPTH];
  logic [fot_pkg::OQ_AW-1:0] oq_wr_r, oq_rd_r;
  logic [fot_pkg::OQ_AW:0]   oq_cnt_r;
  logic [fot_pkg::OQ_AW+1:0] used;
  logic                      oq_push, oq_pop;

  // issue only when every item in flight is sure of a slot
  assign used   = (fot_pkg::OQ_AW+2)'(oq_cnt_r) + (fot_pkg::OQ_AW+2)'(v1_r)
                + (fot_pkg::OQ_AW+2)'(v2_r) + (fot_pkg::OQ_AW+2)'(v3_r)
                + (fot_pkg::OQ_AW+2)'(v4_r);
  assign mq_pop = !mq_st.empty && (used < (fot_pkg::OQ_AW+2)'(fot_pkg::OQ_DEPTH));

  always_ff @(posedge clk) begin
    czdx_r <= head.cz * head.dx;
    czdy_r <= head.cz * head.dy;
    cz2_r  <= head.cz * head.cz;
    bdz_r[0] <= head.b0 * head.dz;
    bdz_r[1] <= head.b1 * head.dz;
    bdz_r[2] <= head.b2 * head.dz;
    bdz_r[3] <= head.b3 * head.dz;
    bb_r[0]  <= head.b0 * head.b0;
    bb_r[1]  <= head.b1 * head.b1;
    bb_r[2]  <= head.b2 * head.b2;
    bb_r[3]  <= head.b3 * head.b3;
    r2_r     <= PW'(head.r) * PW'(head.r);
    rej1_r <= head.rej;
    wp1_r  <= head.w_pos;
    lp1_r  <= head.l_pos;
  end

  always_comb begin
    s_nxt[0] = (PW+1)'(bdz_r[0]) - (PW+1)'(czdx_r);
    s_nxt[1] = (PW+1)'(bdz_r[1]) + (PW+1)'(czdx_r);
    s_nxt[2] = (PW+1)'(bdz_r[2]) + (PW+1)'(czdy_r);
    s_nxt[3] = (PW+1)'(bdz_r[3]) - (PW+1)'(czdy_r);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      act2_r[i] <= !s_nxt[i][PW] && (s_nxt[i] != '0);
      sm_r[i]   <= s_nxt[i][PW-1:0];
      nn_r[i]   <= PW'(cz2_r) + PW'(bb_r[i]);
    end
    r2b_r  <= r2_r;
    rej2_r <= rej1_r;
    wp2_r  <= wp1_r;
    lp2_r  <= lp1_r;
    act3_r <= act2_r;
    rej3_r <= rej2_r;
    wp3_r  <= wp2_r;
    lp3_r  <= lp2_r;
    act4_r <= act3_r;
    rej4_r <= rej3_r;
    wp4_r  <= wp3_r;
    lp4_r  <= lp3_r;
  end

  for (genvar g = 0; g < 4; g++) begin : g_plane
    fot_mul u_sq (.clk(clk), .a(sm_r[g]), .b(sm_r[g]), .p(sq[g]));
    fot_mul u_rn (.clk(clk), .a(r2b_r),   .b(nn_r[g]), .p(rn[g]));
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      beyond[i] = act4_r[i] && (sq[i] > rn[i]);
    end
    occ = !rej4_r && !(wp4_r && (beyond[0] || beyond[1]))
                  && !(lp4_r && (beyond[2] || beyond[3]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= mq_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign oq_push       = v4_r;
  assign out_empty     = (oq_cnt_r == '0);
  assign oq_pop        = out_pop && !out_empty;
  assign out_occluding = oq_mem[oq_rd_r];

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem[oq_wr_r] <= occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) oq_wr_r <= oq_wr_r + 1'b1;
      if (oq_pop)  oq_rd_r <= oq_rd_r + 1'b1;
      if (oq_push && !oq_pop)      oq_cnt_r <= oq_cnt_r + 1'b1;
      else if (!oq_push && oq_pop) oq_cnt_r <= oq_cnt_r - 1'b1;
    end
  end

endmodule

FILE: hdl/field_occlusion_test_unit.sv
// top level of the field occlusion test
//
// usage:
//   input channel: drive the camera position and sphere on in_* and raise
//   in_push; a transfer happens at a clock edge with in_push high and
//   in_full low. one item may be taken every cycle.
//   result channel: while out_empty is low, out_occluding holds the oldest
//   answer; a transfer happens at an edge with out_pop high, out_empty low.
//   config: cfg_valid with cfg_index / cfg_data writes half_length,
//   net_depth or half_width; cfg_ready is always high. write only when idle.
// latency: when nothing waits ahead, an input transfer passes through the
//   queue into the product stage, the sum stage, the two-stage wide
//   multiplier, then the result queue, where out_empty falls.
//   throughput: one item per cycle (fully pipelined) while out_pop keeps up.
// reset: synchronous active-low rst_n clears config, valid flags, both queues.
// receiver stall: results collect in an 8-entry queue; the back end only
//   issues items that are sure of a slot, so the 4-entry queue ahead of it
//   fills and then in_full rises. nothing is dropped.
module field_occlusion_test_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [fot_pkg::CW-1:0]     in_cam_x,
  input  logic signed [fot_pkg::CW-1:0]     in_cam_y,
  input  logic signed [fot_pkg::CW-1:0]     in_cam_z,
  input  logic signed [fot_pkg::CW-1:0]     in_obj_x,
  input  logic signed [fot_pkg::CW-1:0]     in_obj_y,
  input  logic signed [fot_pkg::CW-1:0]     in_obj_z,
  input  logic [fot_pkg::RW-1:0]            in_obj_radius,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_occluding,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [fot_pkg::RW-1:0]            cfg_data
);

  fot_pkg::fot_cfg_t  cfg_r;
  fot_pkg::fot_item_t front_item, head;
  fot_pkg::fot_qctl_t mq_st;
  logic               in_xfer, mq_pop;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fot_pkg::REG_HALF_LENGTH: cfg_r.half_length <= cfg_data;
        fot_pkg::REG_NET_DEPTH:   cfg_r.net_depth   <= cfg_data;
        fot_pkg::REG_HALF_WIDTH:  cfg_r.half_width  <= cfg_data;
        default: ;  // unused index: write ignored
      endcase
    end
  end

  // front end classifies the item on its way into the queue
  fot_front u_front (
    .cfg        (cfg_r),
    .cam_x      (in_cam_x),
    .cam_y      (in_cam_y),
    .cam_z      (in_cam_z),
    .obj_x      (in_obj_x),
    .obj_y      (in_obj_y),
    .obj_z      (in_obj_z),
    .obj_radius (in_obj_radius),
    .item       (front_item)
  );

  assign in_full = mq_st.full;
  assign in_xfer = in_push && !mq_st.full;

  // decoupling queue between the two halves
  fot_mid_queue u_mq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_xfer),
    .item_in  (front_item),
    .pop      (mq_pop),
    .item_out (head),
    .st       (mq_st)
  );

  // back end runs the four plane tests and owns the result queue
  fot_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .mq_st         (mq_st),
    .mq_pop        (mq_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_occluding (out_occluding)
  );

endmodule

FILE: dv/tb_field_occlusion_test_unit.sv
// testbench for the field occlusion test unit: queue-style handshakes, exact predictor
`timescale 1ns / 1ps

module tb_field_occlusion_test_unit;

  typedef logic signed [127:0] wide_t;

  // one camera and sphere pair, held in plain integers
  typedef struct {
    longint cx, cy, cz;
    longint ox, oy, oz;
    longint r;
  } view_t;

  // predicts the occlusion answer and keeps answers not yet seen
  class occlusion_board;
    longint half_length, net_depth, half_width;
    bit     answers[$];
    int     errors;

    function void set_reg(logic [1:0] idx, logic [fot_pkg::RW-1:0] data);
      case (idx)
        fot_pkg::REG_HALF_LENGTH: half_length = data;
        fot_pkg::REG_NET_DEPTH:   net_depth   = data;
        fot_pkg::REG_HALF_WIDTH:  half_width  = data;
        default: ;
      endcase
    endfunction

    // sphere lies wholly on the far side of the plane a*x + b*z
    function bit outside_plane(longint a, longint p, longint b, longint q, longint r);
      wide_t s, n2, rr;
      s  = wide_t'(a) * wide_t'(p) + wide_t'(b) * wide_t'(q);
      n2 = wide_t'(a) * wide_t'(a) + wide_t'(b) * wide_t'(b);
      rr = wide_t'(r) * wide_t'(r);
      if (s <= 0) return 1'b0;
      return (s * s) > (rr * n2);
    endfunction

    function bit occludes(view_t v);
      longint l_ext, w_ext, oz, dx, dy, dz;
      bit cam_in, obj_in;
      l_ext  = half_length + net_depth;
      w_ext  = half_width;
      cam_in = v.cx > -l_ext && v.cx < l_ext && v.cy > -w_ext && v.cy < w_ext;
      obj_in = v.ox > -l_ext && v.ox < l_ext && v.oy > -w_ext && v.oy < w_ext;
      if (cam_in && !obj_in) return 1'b0;
      if ((v.cx < -l_ext && v.ox > l_ext) || (v.cx > l_ext && v.ox < -l_ext) ||
          (v.cy < -w_ext && v.oy > w_ext) || (v.cy > w_ext && v.oy < -w_ext))
        return 1'b0;
      // lift a sunken sphere onto the ground
      oz = (v.oz < v.r) ? v.r : v.oz;
      dx = v.ox - v.cx;
      dy = v.oy - v.cy;
      dz = oz - v.cz;
      if (w_ext > 0 && (outside_plane(-v.cz, dx, l_ext + v.cx, dz, v.r) ||
                        outside_plane(v.cz, dx, l_ext - v.cx, dz, v.r)))
        return 1'b0;
      if (l_ext > 0 && (outside_plane(v.cz, dy, w_ext - v.cy, dz, v.r) ||
                        outside_plane(-v.cz, dy, w_ext + v.cy, dz, v.r)))
        return 1'b0;
      return 1'b1;
    endfunction

    function void note_view(view_t v);
      answers.push_back(occludes(v));
    endfunction

    function void check_answer(bit got);
      bit want;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result occluding=%0b", $realtime, got);
        errors++;
        return;
      end
      want = answers.pop_front();
      if (want !== got) begin
        $display("%0t: occluding mismatch expected %0b actual %0b", $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_push = 1'b0;
  logic                          in_full;
  logic signed [fot_pkg::CW-1:0] in_cam_x = '0, in_cam_y = '0, in_cam_z = '0;
  logic signed [fot_pkg::CW-1:0] in_obj_x = '0, in_obj_y = '0, in_obj_z = '0;
  logic [fot_pkg::RW-1:0]        in_obj_radius = '0;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic                          out_occluding;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index = fot_pkg::REG_HALF_LENGTH;
  logic [fot_pkg::RW-1:0]        cfg_data = '0;

  occlusion_board board = new();

  // idle percentages per side, and the long receiver hold-off
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold = 0;
  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;

  field_occlusion_test_unit uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  initial begin
    #4000000;
    $display("tb_field_occlusion_test_unit: FAIL");
    $finish;
  end

  // sample every transfer at the rising edge, with pre-edge values
  always @(posedge clk) begin
    view_t v;
    in_taken  <= in_push && !in_full && rst_n;
    cfg_taken <= cfg_valid && cfg_ready && rst_n;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
      if (in_push && !in_full) begin
        v.cx = in_cam_x; v.cy = in_cam_y; v.cz = in_cam_z;
        v.ox = in_obj_x; v.oy = in_obj_y; v.oz = in_obj_z;
        v.r  = in_obj_radius;
        board.note_view(v);
      end
      if (out_pop && !out_empty) board.check_answer(out_occluding);
    end
  end

  // receiver: random stalls, plus a counted hold-off when asked
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop = 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      out_pop = 1'b0;
    end else begin
      out_pop = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // register write, only while the unit is idle
  task automatic write_reg(logic [1:0] idx, logic [fot_pkg::RW-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
  endtask

  task automatic set_field(logic [fot_pkg::RW-1:0] hl, logic [fot_pkg::RW-1:0] nd,
                           logic [fot_pkg::RW-1:0] hw);
    write_reg(fot_pkg::REG_HALF_LENGTH, hl);
    write_reg(fot_pkg::REG_NET_DEPTH, nd);
    write_reg(fot_pkg::REG_HALF_WIDTH, hw);
  endtask

  // offer one item, idling at random first; returns at a falling edge after transfer
  task automatic send_view(view_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_cam_x = fot_pkg::CW'(v.cx); in_cam_y = fot_pkg::CW'(v.cy);
    in_cam_z = fot_pkg::CW'(v.cz);
    in_obj_x = fot_pkg::CW'(v.ox); in_obj_y = fot_pkg::CW'(v.oy);
    in_obj_z = fot_pkg::CW'(v.oz);
    in_obj_radius = fot_pkg::RW'(v.r);
    in_push = 1'b1;
    do @(negedge clk); while (!in_taken);
  endtask

  // wait until every answer is back, then let the pipe settle
  task automatic drain();
    in_push = 1'b0;
    while (board.answers.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic longint pick(longint span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  function automatic longint rand_coord();
    return longint'($signed(fot_pkg::CW'($urandom())));
  endfunction

  // mostly views around the field, some fully random noise
  function automatic view_t random_view();
    view_t  v;
    longint span;
    int     kind;
    kind = $urandom_range(9);
    span = board.half_length + board.net_depth;
    if (board.half_width > span) span = board.half_width;
    span = 2 * span + 256;
    if (span > 8388607) span = 8388607;
    if (kind < 2) begin
      v.cx = rand_coord(); v.cy = rand_coord(); v.cz = rand_coord();
      v.ox = rand_coord(); v.oy = rand_coord(); v.oz = rand_coord();
      v.r  = $urandom_range(8388607);
    end else begin
      v.cx = pick(span); v.cy = pick(span);
      v.cz = (kind < 8) ? longint'($urandom_range(span)) : pick(span);
      // object mostly between the camera and the ground
      v.ox = (v.cx + pick(span)) / 2; v.oy = (v.cy + pick(span)) / 2;
      v.oz = pick(span) / 4;
      v.r  = (kind == 9) ? $urandom_range(span) : $urandom_range(span / 16);
      if (v.ox < -8388608) v.ox = -8388608;
      if (v.oy < -8388608) v.oy = -8388608;
    end
    return v;
  endfunction

  task automatic directed_views();
    view_t v;
    // camera inside the field, object outside
    v = '{0, 0, 512, 30000, 0, 0, 10};              send_view(v);
    // camera beyond one goal line, object beyond the other
    v = '{-30000, 0, 2560, 30000, 0, 3000, 100};     send_view(v);
    v = '{30000, 0, 2560, -30000, 0, 3000, 100};     send_view(v);
    // same across the sidelines
    v = '{0, 20000, 5000, 0, -20000, 0, 100};        send_view(v);
    v = '{0, -20000, 5000, 0, 20000, 0, 100};        send_view(v);
    // object exactly on the boundary, comparisons are strict
    v = '{0, 0, 512, 20600, 0, 0, 10};               send_view(v);
    v = '{-20600, 0, 4000, 20600, 0, 0, 10};         send_view(v);
    // sunken sphere lifted to its radius
    v = '{0, -20000, 5000, 0, -2000, -1000, 512};    send_view(v);
    // camera high over the middle, large sphere just below it
    v = '{0, 0, 100000, 0, 0, 90000, 20000};         send_view(v);
    v = '{0, -40000, 8000, 0, -30000, 2000, 0};      send_view(v);
    v = '{0, -40000, 8000, 0, -30000, 2000, 8388607}; send_view(v);
    // field extremes
    v = '{-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, 0}; send_view(v);
    v = '{8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607}; send_view(v);
    v = '{-8388608, 8388607, 8388607, 8388607, -8388608, -8388608, 8388607};
    send_view(v);
    v = '{0, 0, 0, 0, 0, 0, 0};                      send_view(v);
  endtask

  initial begin
    int idle_modes[4][2];
    logic [fot_pkg::RW-1:0] field[6][3];
    int phase, k;
    idle_modes = '{'{0, 0}, '{72, 0}, '{0, 72}, '{10, 10}};
    field[0] = '{20000, 600, 13000};
    field[1] = '{0, 0, 8388607};          // zero length: side planes never reject
    field[2] = '{5000, 0, 0};             // zero width: goal planes never reject
    field[3] = '{8388607, 8388607, 8388607};
    field[4] = '{fot_pkg::RW'($urandom_range(60000)), fot_pkg::RW'($urandom_range(3000)),
                 fot_pkg::RW'($urandom_range(40000))};
    field[5] = '{30000, 1200, 18000};

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    for (phase = 0; phase < 6; phase++) begin
      set_field(field[phase][0], field[phase][1], field[phase][2]);
      if (phase == 0) directed_views();
      for (k = 0; k < 132; k++) begin
        // idling mode changes every quarter so each mode hits each phase
        send_idle_pct  = idle_modes[(k / 33 + phase) % 4][0];
        recv_stall_pct = idle_modes[(k / 33 + phase) % 4][1];
        // long receiver hold-off while items keep coming, to fill the unit
        if (phase == 5 && k == 10) begin
          send_idle_pct  = 0;
          recv_hold = 300;
        end
        send_view(random_view());
      end
      drain();
    end

    if (board.errors == 0 && board.answers.size() == 0)
      $display("tb_field_occlusion_test_unit: PASS");
    else
      $display("tb_field_occlusion_test_unit: FAIL");
    $finish;
  end

endmodule

FILE: files.f
hdl/fot_pkg.sv
hdl/fot_front.sv
hdl/fot_mid_queue.sv
hdl/fot_mul.sv
hdl/fot_back.sv
hdl/field_occlusion_test_unit.sv
dv/tb_field_occlusion_test_unit.sv
